// ===== hdl/mmcs_pkg.sv =====
// Shared types and constants for the min-max contrast stretch block.
// No dependencies; used by every module under hdl/.
`default_nettype none
package mmcs_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int SAMPLE_W      = 32;
  localparam int LEVEL_W       = 8;
  localparam int IDX_W         = $clog2(LEVEL_W);
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;

  // Range used when nothing valid was measured, and reset of fixed_high.
  localparam logic signed [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'(255 << FRACTION_BITS);
  localparam logic signed [SAMPLE_W-1:0] FIXED_HIGH_RESET = 32'sd65280;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  localparam logic [LEVEL_W-1:0] LEVEL_MID = 8'd127;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_LOW     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_HIGH    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NODATA_VALUE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NODATA_ENABLE = 3'd4;

  // Item op codes.
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_STRETCH = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_frame;
    logic                       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               is_missing;
    logic               last_level;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             setup;
    logic             step;
    logic [IDX_W-1:0] bit_idx;
    logic             load;
  } cmd_t;

  typedef struct packed {
    logic item_op;
    logic quick;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/mmcs_ctrl.sv =====
// Controller FSM: sequences capture, setup, divide steps and result load.
// Depends on mmcs_pkg.
`default_nettype none
module mmcs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mmcs_pkg::status_t status,
  output mmcs_pkg::cmd_t        cmd
);

  mmcs_pkg::state_t                state, state_next;
  logic [mmcs_pkg::IDX_W-1:0]      count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmcs_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    cmd         = '0;
    cmd.bit_idx = count;
    in_stall    = 1'b1;
    case (state)
      mmcs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (status.item_op == mmcs_pkg::OP_STRETCH) state_next = mmcs_pkg::ST_SETUP;
        end
      end
      mmcs_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        if (status.quick) begin
          state_next = mmcs_pkg::ST_EMIT;
        end else begin
          state_next = mmcs_pkg::ST_DIV;
          count_next = '1;
        end
      end
      mmcs_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (count == '0) state_next = mmcs_pkg::ST_EMIT;
        else count_next = count - 1'b1;
      end
      mmcs_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = mmcs_pkg::ST_IDLE;
        end
      end
      default: state_next = mmcs_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/mmcs_dp.sv =====
// Datapath: config registers, running min/max, range select, restoring
// divider and output register. Depends on mmcs_pkg.
`default_nettype none
module mmcs_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [mmcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mmcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire mmcs_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output mmcs_pkg::out_item_t                      out_data,
  input  wire mmcs_pkg::cmd_t                      cmd,
  output mmcs_pkg::status_t                        status
);

  localparam int DIFF_W = mmcs_pkg::SAMPLE_W + 1;
  localparam int REM_W  = DIFF_W + mmcs_pkg::LEVEL_W;

  // configuration
  logic                                range_mode;
  logic signed [mmcs_pkg::SAMPLE_W-1:0] fixed_low, fixed_high, nodata_value;
  logic                                nodata_enable;

  // running range
  logic signed [mmcs_pkg::SAMPLE_W-1:0] seen_low, seen_high;
  logic                                any_valid;

  // captured stretch item
  logic signed [mmcs_pkg::SAMPLE_W-1:0] s_r, low_r, high_r;
  logic                                missing_r, last_r;

  // divider
  logic [REM_W-1:0]                    rem;
  logic [DIFF_W-1:0]                   den;
  logic [mmcs_pkg::LEVEL_W-1:0]        res_level;

  logic                                missing_in;
  logic signed [mmcs_pkg::SAMPLE_W-1:0] base_low, base_high, sel_low, sel_high;
  logic signed [DIFF_W-1:0]            diff, span;
  logic                                empty_range, below, above;
  logic [REM_W-1:0]                    den_sh;
  logic [REM_W:0]                      trial;

  assign missing_in = nodata_enable && (in_data.sample == nodata_value);
  assign base_low   = in_data.first_of_frame ? mmcs_pkg::SAMPLE_MAX : seen_low;
  assign base_high  = in_data.first_of_frame ? mmcs_pkg::SAMPLE_MIN : seen_high;

  always_comb begin
    if (range_mode) begin
      sel_low  = fixed_low;
      sel_high = fixed_high;
    end else if (any_valid) begin
      sel_low  = seen_low;
      sel_high = seen_high;
    end else begin
      sel_low  = '0;
      sel_high = mmcs_pkg::FULL_SCALE;
    end
  end

  assign diff        = DIFF_W'(s_r) - DIFF_W'(low_r);
  assign span        = DIFF_W'(high_r) - DIFF_W'(low_r);
  assign empty_range = (high_r <= low_r);
  assign below       = (s_r <= low_r);
  assign above       = (s_r >= high_r);

  assign den_sh = REM_W'(den) << cmd.bit_idx;
  assign trial  = {1'b0, rem} - {1'b0, den_sh};

  assign status.item_op  = in_data.op;
  assign status.quick    = missing_r || empty_range || below || above;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode    <= 1'b0;
      fixed_low     <= '0;
      fixed_high    <= mmcs_pkg::FIXED_HIGH_RESET;
      nodata_value  <= '0;
      nodata_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mmcs_pkg::REG_RANGE_MODE:    range_mode    <= cfg_data[0];
        mmcs_pkg::REG_FIXED_LOW:     fixed_low     <= cfg_data;
        mmcs_pkg::REG_FIXED_HIGH:    fixed_high    <= cfg_data;
        mmcs_pkg::REG_NODATA_VALUE:  nodata_value  <= cfg_data;
        mmcs_pkg::REG_NODATA_ENABLE: nodata_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_low  <= mmcs_pkg::SAMPLE_MAX;
      seen_high <= mmcs_pkg::SAMPLE_MIN;
      any_valid <= 1'b0;
    end else if (cmd.capture && in_data.op == mmcs_pkg::OP_MEASURE) begin
      if (missing_in) begin
        seen_low  <= base_low;
        seen_high <= base_high;
        any_valid <= any_valid && !in_data.first_of_frame;
      end else begin
        seen_low  <= (in_data.sample < base_low)  ? in_data.sample : base_low;
        seen_high <= (in_data.sample > base_high) ? in_data.sample : base_high;
        any_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_r       <= in_data.sample;
      low_r     <= sel_low;
      high_r    <= sel_high;
      missing_r <= missing_in;
      last_r    <= in_data.end_of_frame;
    end
    if (cmd.setup) begin
      // rem = diff * 255; only meaningful when low < s < high
      rem <= (REM_W'(diff) << mmcs_pkg::LEVEL_W) - REM_W'(diff);
      den <= span;
      if (missing_r)        res_level <= '0;
      else if (empty_range) res_level <= mmcs_pkg::LEVEL_MID;
      else if (below)       res_level <= '0;
      else if (above)       res_level <= mmcs_pkg::LEVEL_TOP;
      else                  res_level <= '0;
    end
    if (cmd.step && !trial[REM_W]) begin
      rem                    <= trial[REM_W-1:0];
      res_level[cmd.bit_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.level      <= res_level;
      out_data.is_missing <= missing_r;
      out_data.last_level <= last_r;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/minmax_contrast_stretch.sv =====
// Min-max contrast stretch: signed fixed-point samples to 8-bit levels.
// Measure item: no result; the next item can follow at once.
// Stretch item: setup, 8 restoring-divide steps and result load when a division
//   is needed, setup and load only for missing, empty-range or clamped samples;
//   the load waits for a free output register; no new item is taken meanwhile.
// rst (sync, active high) restores register defaults and clears the running range.
`default_nettype none
module minmax_contrast_stretch (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [mmcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mmcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire mmcs_pkg::in_item_t               in_data,
  // result items
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output mmcs_pkg::out_item_t                   out_data
);

  // Controller and datapath talk only through these two bundles.
  mmcs_pkg::cmd_t    cmd;
  mmcs_pkg::status_t status;

  // FSM: idle/capture -> setup (range tests, numerator) -> 8 divide steps,
  // skipped if setup settles the level -> load the output register once free.
  mmcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: a measure item updates min/max at the accept edge, so a
  // following stretch item already sees the new range. The output register
  // lets a result wait for the consumer while the next item is taken in.
  mmcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire
